// ----- hdl/cva_pkg.sv -----
// ---------------------------------------------------------------------------
// cva_pkg
// Shared types, constants and the triangle index table of the cube vertex
// normal averager.
// ---------------------------------------------------------------------------
package cva_pkg;

   localparam int VERTEX_COUNT = 8;
   localparam int TRI_COUNT    = 12;
   localparam int PROD_COUNT   = 6;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 16;
   localparam logic signed [15:0] ONE_Q15 = 16'sd32767;

   localparam logic [2:0] LAST_VERTEX = 3'(VERTEX_COUNT - 1);
   localparam logic [3:0] LAST_TRI    = 4'(TRI_COUNT - 1);
   localparam logic [2:0] LAST_PROD   = 3'(PROD_COUNT - 1);

   // three corners per triangle, wound so the cross product points outwards
   localparam logic [2:0] TRI_TABLE [0:35] = '{
      3'd0, 3'd2, 3'd1,  3'd1, 3'd2, 3'd3,
      3'd4, 3'd5, 3'd6,  3'd5, 3'd7, 3'd6,
      3'd0, 3'd4, 3'd2,  3'd2, 3'd4, 3'd6,
      3'd1, 3'd3, 3'd5,  3'd3, 3'd7, 3'd5,
      3'd2, 3'd6, 3'd3,  3'd3, 3'd6, 3'd7,
      3'd0, 3'd1, 3'd4,  3'd1, 3'd5, 3'd4
   };

   typedef enum logic [4:0] {
      OP_NOP,
      OP_WRITE,
      OP_CLEAR,
      OP_FETCH,
      OP_DIFF,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_MUL_SUM,
      OP_CROSS,
      OP_ACC_RD,
      OP_ACC_WR,
      OP_NRM_RD,
      OP_NRM_LOAD,
      OP_NRM_MAX,
      OP_SHIFT,
      OP_SQ,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_END,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] idx;
      logic [2:0] sel;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_zero;
      logic rsp_busy;
   } status_type;

   function automatic logic [2:0] tri_vertex(input logic [3:0] tri_idx,
                                             input logic [1:0] corner);
      logic [5:0] pos;
      pos = 6'(tri_idx) * 6'd3 + 6'(corner);
      return TRI_TABLE[pos];
   endfunction

endpackage

// ----- hdl/cva_if.sv -----
// ---------------------------------------------------------------------------
// cva_req_if / cva_rsp_if
// Valid/ready channels carrying corner positions in and averaged normals out.
// ---------------------------------------------------------------------------
interface cva_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface cva_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         vertex_index;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_pos_z;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               last;

   modport source (output valid, output vertex_index, output out_pos_x, output out_pos_y,
                   output out_pos_z, output normal_x, output normal_y, output normal_z,
                   output last, input ready);
   modport sink   (input valid, input vertex_index, input out_pos_x, input out_pos_y,
                   input out_pos_z, input normal_x, input normal_y, input normal_z,
                   input last, output ready);
endinterface

// ----- hdl/cva_datapath.sv -----
// ---------------------------------------------------------------------------
// cva_datapath
// Corner and normal stores, shared multiplier, square-root and divider
// units, and the response output register, all driven by controller commands.
// ---------------------------------------------------------------------------
module cva_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  cva_pkg::cmd_type       cmd,
   output cva_pkg::status_type    stat,
   input  logic signed [31:0]     pos_x,
   input  logic signed [31:0]     pos_y,
   input  logic signed [31:0]     pos_z,
   cva_rsp_if.source              rsp_bus
);

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

   // stores: {x, y, z}
   logic [95:0]  store_mem [0:7];
   logic [191:0] acc_mem   [0:7];
   logic [95:0]  st_rd_ff;
   logic [191:0] acc_rd_ff;

   logic [95:0]        v0_ff, v1_ff, v2_ff;
   logic signed [32:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [49:0] pp_lo_ff, pp_hi_ff;
   logic signed [49:0] pr_ff [0:5];
   logic signed [63:0] cx_ff, cy_ff, cz_ff;
   logic [2:0]         neg_ff;
   logic [63:0]        mag_ff [0:2];
   logic [63:0]        m_ff;
   logic [95:0]        pos_ff;
   logic [59:0]        sq_ff;
   logic [61:0]        sum_ff;
   logic [63:0]        rv_ff, res_ff, bit_ff;
   logic [31:0]        rem_ff;
   logic [15:0]        nlo_ff, q_ff;
   logic signed [15:0] nrm_ff [0:2];

   logic               rsp_valid_ff;
   logic [2:0]         vidx_ff;
   logic [95:0]        opos_ff;
   logic signed [15:0] onx_ff, ony_ff, onz_ff;
   logic               last_ff;

   logic signed [32:0] opa, opb;
   logic signed [49:0] opa_w, mul_b, mul_in;
   logic [29:0]        comp;
   logic [59:0]        sq_in;
   logic signed [63:0] acc_x_in, acc_y_in, acc_z_in;
   logic [63:0]        root_try;
   logic [31:0]        len;
   logic [45:0]        num_in;
   logic [32:0]        rem_try;
   logic [14:0]        q_clip;
   logic signed [15:0] q_signed;
   logic [63:0]        mag_in [0:2];
   logic [63:0]        max_xy;
   logic               zero_w;

   // --- corner store -------------------------------------------------------
   always_ff @(posedge clock) begin
      if (cmd.op == cva_pkg::OP_WRITE) begin
         store_mem[cmd.idx] <= {pos_x, pos_y, pos_z};
      end
      if (cmd.op == cva_pkg::OP_FETCH || cmd.op == cva_pkg::OP_NRM_RD) begin
         st_rd_ff <= store_mem[cmd.idx];
      end
   end

   // --- normal sum store ---------------------------------------------------
   assign acc_x_in = sat_add(acc_rd_ff[191:128], cx_ff);
   assign acc_y_in = sat_add(acc_rd_ff[127:64], cy_ff);
   assign acc_z_in = sat_add(acc_rd_ff[63:0], cz_ff);

   always_ff @(posedge clock) begin
      if (cmd.op == cva_pkg::OP_CLEAR) begin
         acc_mem[cmd.idx] <= '0;
      end else if (cmd.op == cva_pkg::OP_ACC_WR) begin
         acc_mem[cmd.idx] <= {acc_x_in, acc_y_in, acc_z_in};
      end
      if (cmd.op == cva_pkg::OP_ACC_RD || cmd.op == cva_pkg::OP_NRM_RD) begin
         acc_rd_ff <= acc_mem[cmd.idx];
      end
   end

   // --- shared multiplier: 33 x 17 bits per pass ---------------------------
   always_comb begin
      unique case (cmd.sel)
         3'd0:    begin opa = ay_ff; opb = bz_ff; end
         3'd1:    begin opa = az_ff; opb = by_ff; end
         3'd2:    begin opa = az_ff; opb = bx_ff; end
         3'd3:    begin opa = ax_ff; opb = bz_ff; end
         3'd4:    begin opa = ax_ff; opb = by_ff; end
         3'd5:    begin opa = ay_ff; opb = bx_ff; end
         default: begin opa = ay_ff; opb = bz_ff; end
      endcase
   end

   assign opa_w  = 50'(opa);
   assign mul_b  = (cmd.op == cva_pkg::OP_MUL_HI) ? 50'($signed(opb[32:16]))
                                                  : 50'($signed({1'b0, opb[15:0]}));
   assign mul_in = opa_w * mul_b;

   // --- normalising helpers ------------------------------------------------
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = acc_rd_ff[191 - 64 * i -: 64];
         if (mag_in[i][63]) begin
            mag_in[i] = 64'd0 - mag_in[i];
         end
      end
   end

   assign max_xy = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign zero_w = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);

   always_comb begin
      unique case (cmd.sel)
         3'd0:    comp = mag_ff[0][29:0];
         3'd1:    comp = mag_ff[1][29:0];
         3'd2:    comp = mag_ff[2][29:0];
         default: comp = mag_ff[0][29:0];
      endcase
   end

   assign sq_in    = 60'(comp) * 60'(comp);
   assign root_try = res_ff + bit_ff;
   assign len      = res_ff[31:0];
   assign num_in   = 46'({comp, 15'd0}) + 46'(len >> 1);
   assign rem_try  = {rem_ff, nlo_ff[15]};
   assign q_clip   = q_ff[15] ? 15'h7fff : q_ff[14:0];
   assign q_signed = {1'b0, q_clip};

   // --- datapath registers -------------------------------------------------
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         cva_pkg::OP_FETCH: begin
            unique case (cmd.sel)
               3'd1:    v0_ff <= st_rd_ff;
               3'd2:    v1_ff <= st_rd_ff;
               3'd3:    v2_ff <= st_rd_ff;
               default: ;
            endcase
         end
         cva_pkg::OP_DIFF: begin
            ax_ff <= 33'($signed(v1_ff[95:64])) - 33'($signed(v0_ff[95:64]));
            ay_ff <= 33'($signed(v1_ff[63:32])) - 33'($signed(v0_ff[63:32]));
            az_ff <= 33'($signed(v1_ff[31:0]))  - 33'($signed(v0_ff[31:0]));
            bx_ff <= 33'($signed(v2_ff[95:64])) - 33'($signed(v0_ff[95:64]));
            by_ff <= 33'($signed(v2_ff[63:32])) - 33'($signed(v0_ff[63:32]));
            bz_ff <= 33'($signed(v2_ff[31:0]))  - 33'($signed(v0_ff[31:0]));
         end
         cva_pkg::OP_MUL_LO: pp_lo_ff <= mul_in;
         cva_pkg::OP_MUL_HI: pp_hi_ff <= mul_in;
         // floor of the full product over 2^16
         cva_pkg::OP_MUL_SUM: pr_ff[cmd.sel] <= pp_hi_ff + (pp_lo_ff >>> 16);
         cva_pkg::OP_CROSS: begin
            cx_ff <= 64'(pr_ff[0]) - 64'(pr_ff[1]);
            cy_ff <= 64'(pr_ff[2]) - 64'(pr_ff[3]);
            cz_ff <= 64'(pr_ff[4]) - 64'(pr_ff[5]);
         end
         cva_pkg::OP_NRM_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_in[i];
               neg_ff[i] <= acc_rd_ff[191 - 64 * i];
            end
            pos_ff <= st_rd_ff;
         end
         cva_pkg::OP_NRM_MAX: m_ff <= (mag_ff[2] > max_xy) ? mag_ff[2] : max_xy;
         cva_pkg::OP_SHIFT: begin
            // move the largest magnitude into [2^29, 2^30), all three together
            if (m_ff[63:30] != '0) begin
               m_ff <= m_ff >> 1;
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
            end else begin
               m_ff <= m_ff << 1;
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
            end
         end
         cva_pkg::OP_SQ: begin
            sq_ff  <= sq_in;
            sum_ff <= (cmd.sel == 3'd0) ? 62'd0 : sum_ff + 62'(sq_ff);
         end
         cva_pkg::OP_SQRT_INIT: begin
            rv_ff  <= 64'(sum_ff);
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         cva_pkg::OP_SQRT_STEP: begin
            if (rv_ff >= root_try) begin
               rv_ff  <= rv_ff - root_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         cva_pkg::OP_DIV_INIT: begin
            rem_ff <= 32'(num_in[45:16]);
            nlo_ff <= num_in[15:0];
            q_ff   <= '0;
         end
         cva_pkg::OP_DIV_STEP: begin
            if (rem_try >= {1'b0, len}) begin
               rem_ff <= 32'(rem_try - {1'b0, len});
               q_ff   <= {q_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem_try[31:0];
               q_ff   <= {q_ff[14:0], 1'b0};
            end
            nlo_ff <= nlo_ff << 1;
         end
         cva_pkg::OP_DIV_END: begin
            unique case (cmd.sel)
               3'd0:    nrm_ff[0] <= neg_ff[0] ? -q_signed : q_signed;
               3'd1:    nrm_ff[1] <= neg_ff[1] ? -q_signed : q_signed;
               3'd2:    nrm_ff[2] <= neg_ff[2] ? -q_signed : q_signed;
               default: ;
            endcase
         end
         cva_pkg::OP_EMIT: begin
            vidx_ff <= cmd.idx;
            opos_ff <= pos_ff;
            last_ff <= (cmd.idx == cva_pkg::LAST_VERTEX);
            if (zero_w) begin
               onx_ff <= '0;
               ony_ff <= cva_pkg::ONE_Q15;
               onz_ff <= '0;
            end else begin
               onx_ff <= nrm_ff[0];
               ony_ff <= nrm_ff[1];
               onz_ff <= nrm_ff[2];
            end
         end
         default: ;
      endcase
   end

   // --- output register ----------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == cva_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.vertex_index = vidx_ff;
   assign rsp_bus.out_pos_x    = opos_ff[95:64];
   assign rsp_bus.out_pos_y    = opos_ff[63:32];
   assign rsp_bus.out_pos_z    = opos_ff[31:0];
   assign rsp_bus.normal_x     = onx_ff;
   assign rsp_bus.normal_y     = ony_ff;
   assign rsp_bus.normal_z     = onz_ff;
   assign rsp_bus.last         = last_ff;

   assign stat.in_range = (m_ff[63:30] == '0) && m_ff[29];
   assign stat.is_zero  = zero_w;
   assign stat.rsp_busy = rsp_valid_ff;

endmodule

// ----- hdl/cva_ctrl.sv -----
// ---------------------------------------------------------------------------
// cva_ctrl
// Sequencer: loads the corners, walks the triangle table, then normalises
// and emits each corner in turn.
// ---------------------------------------------------------------------------
module cva_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output cva_pkg::cmd_type    cmd,
   input  cva_pkg::status_type stat
);

   typedef enum logic [14:0] {
      S_LOAD   = 15'h0001,
      S_CLEAR  = 15'h0002,
      S_FETCH  = 15'h0004,
      S_DIFF   = 15'h0008,
      S_MUL    = 15'h0010,
      S_CROSS  = 15'h0020,
      S_ACC    = 15'h0040,
      S_NRD    = 15'h0080,
      S_NLOAD  = 15'h0100,
      S_NMAX   = 15'h0200,
      S_NSHIFT = 15'h0400,
      S_SQ     = 15'h0800,
      S_SQRT   = 15'h1000,
      S_DIV    = 15'h2000,
      S_EMIT   = 15'h4000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [3:0] tri_ff, tri_in;
   logic [5:0] sub_ff, sub_in;
   logic [2:0] sel_ff, sel_in;
   logic [2:0] vtx_ff, vtx_in;
   logic [1:0] corner;

   assign corner = (sub_ff[1:0] == 2'd3) ? 2'd0 : sub_ff[1:0];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      tri_in    = tri_ff;
      sub_in    = sub_ff;
      sel_in    = sel_ff;
      vtx_in    = vtx_ff;
      req_ready = 1'b0;
      cmd.op    = cva_pkg::OP_NOP;
      cmd.idx   = '0;
      cmd.sel   = '0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op  = cva_pkg::OP_WRITE;
               cmd.idx = cnt_ff;
               cnt_in  = cnt_ff + 3'd1;
               if (cnt_ff == cva_pkg::LAST_VERTEX) begin
                  vtx_in   = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            cmd.op  = cva_pkg::OP_CLEAR;
            cmd.idx = vtx_ff;
            vtx_in  = vtx_ff + 3'd1;
            if (vtx_ff == cva_pkg::LAST_VERTEX) begin
               tri_in   = '0;
               sub_in   = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // read one corner per cycle, capture it the cycle after
            cmd.op  = cva_pkg::OP_FETCH;
            cmd.sel = sub_ff[2:0];
            cmd.idx = cva_pkg::tri_vertex(tri_ff, corner);
            sub_in  = sub_ff + 6'd1;
            if (sub_ff == 6'd3) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.op   = cva_pkg::OP_DIFF;
            sub_in   = '0;
            sel_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.sel = sel_ff;
            priority if (sub_ff == 6'd0) cmd.op = cva_pkg::OP_MUL_LO;
            else if (sub_ff == 6'd1)     cmd.op = cva_pkg::OP_MUL_HI;
            else                         cmd.op = cva_pkg::OP_MUL_SUM;
            sub_in = sub_ff + 6'd1;
            if (sub_ff == 6'd2) begin
               sub_in = '0;
               sel_in = sel_ff + 3'd1;
               if (sel_ff == cva_pkg::LAST_PROD) begin
                  state_in = S_CROSS;
               end
            end
         end
         S_CROSS: begin
            cmd.op   = cva_pkg::OP_CROSS;
            sub_in   = '0;
            sel_in   = '0;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.idx = cva_pkg::tri_vertex(tri_ff, sel_ff[1:0]);
            cmd.op  = sub_ff[0] ? cva_pkg::OP_ACC_WR : cva_pkg::OP_ACC_RD;
            sub_in  = 6'd1;
            if (sub_ff[0]) begin
               sub_in = '0;
               sel_in = sel_ff + 3'd1;
               if (sel_ff == 3'd2) begin
                  sel_in = '0;
                  if (tri_ff == cva_pkg::LAST_TRI) begin
                     vtx_in   = '0;
                     state_in = S_NRD;
                  end else begin
                     tri_in   = tri_ff + 4'd1;
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_NRD: begin
            cmd.op   = cva_pkg::OP_NRM_RD;
            cmd.idx  = vtx_ff;
            state_in = S_NLOAD;
         end
         S_NLOAD: begin
            cmd.op   = cva_pkg::OP_NRM_LOAD;
            state_in = S_NMAX;
         end
         S_NMAX: begin
            cmd.op   = cva_pkg::OP_NRM_MAX;
            state_in = stat.is_zero ? S_EMIT : S_NSHIFT;
         end
         S_NSHIFT: begin
            if (stat.in_range) begin
               sub_in   = '0;
               state_in = S_SQ;
            end else begin
               cmd.op = cva_pkg::OP_SHIFT;
            end
         end
         S_SQ: begin
            cmd.op  = cva_pkg::OP_SQ;
            cmd.sel = sub_ff[2:0];
            sub_in  = sub_ff + 6'd1;
            if (sub_ff == 6'd3) begin
               sub_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = (sub_ff == 6'd0) ? cva_pkg::OP_SQRT_INIT : cva_pkg::OP_SQRT_STEP;
            sub_in = sub_ff + 6'd1;
            if (sub_ff == 6'(cva_pkg::SQRT_STEPS)) begin
               sub_in   = '0;
               sel_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.sel = sel_ff;
            priority if (sub_ff == 6'd0)                        cmd.op = cva_pkg::OP_DIV_INIT;
            else if (sub_ff == 6'(cva_pkg::DIV_STEPS + 1))      cmd.op = cva_pkg::OP_DIV_END;
            else                                                cmd.op = cva_pkg::OP_DIV_STEP;
            sub_in = sub_ff + 6'd1;
            if (sub_ff == 6'(cva_pkg::DIV_STEPS + 1)) begin
               sub_in = '0;
               sel_in = sel_ff + 3'd1;
               if (sel_ff == 3'd2) begin
                  sel_in   = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            // hold until the previous output has been taken
            if (!stat.rsp_busy) begin
               cmd.op  = cva_pkg::OP_EMIT;
               cmd.idx = vtx_ff;
               vtx_in  = vtx_ff + 3'd1;
               state_in = (vtx_ff == cva_pkg::LAST_VERTEX) ? S_LOAD : S_NRD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         tri_ff   <= '0;
         sub_ff   <= '0;
         sel_ff   <= '0;
         vtx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         tri_ff   <= tri_in;
         sub_ff   <= sub_in;
         sel_ff   <= sel_in;
         vtx_ff   <= vtx_in;
      end
   end

`ifndef ASSERT_OFF
   a_ready_drops_after_eighth: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && cnt_ff == cva_pkg::LAST_VERTEX) |=> !req_ready)
      else $error("request taken beyond the eighth corner");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cva_pkg::OP_EMIT) |-> !stat.rsp_busy)
      else $error("emit over a pending output");

   a_square_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQ) |-> stat.in_range)
      else $error("squares taken before normalising shift finished");
`endif

endmodule

// ----- hdl/cube_vertex_normal_averager_core.sv -----
// ---------------------------------------------------------------------------
// cube_vertex_normal_averager_core
// Per-vertex normal averaging over the 12 triangles of a cube mesh.
// ---------------------------------------------------------------------------
// Requests one to seven are taken back to back, one per cycle. The eighth
// starts a run: the normal sums are cleared, every triangle is added in
// (shared 33x17 multiplier), then each of the 8 corners is normalised
// unless its sum is zero (shift search, 32-step square root, three
// divides) and emitted; no new request is taken until the last output.
// Synchronous reset clears the sequencer and the output valid; stores are not.
module cube_vertex_normal_averager_core (
   input  logic      clock,
   input  logic      reset,
   cva_req_if.sink   req_bus,
   cva_rsp_if.source rsp_bus
);

   cva_pkg::cmd_type    cmd;
   cva_pkg::status_type stat;

   cva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cva_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (stat),
      .pos_x   (req_bus.pos_x),
      .pos_y   (req_bus.pos_y),
      .pos_z   (req_bus.pos_z),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- dv/cva_tb_if.sv -----
// ---------------------------------------------------------------------------
// cva_tb_pkg
// Testbench types: the expected content of one emitted corner.
// ---------------------------------------------------------------------------
package cva_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]         vertex_index;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               last;
   } corner_normal_type;
endpackage

// ----- dv/cube_vertex_normal_averager_core_tb.sv -----
// ---------------------------------------------------------------------------
// cube_vertex_normal_averager_core_tb
// Drives cube corner sets into the averager with random gaps and stalls and
// checks every emitted corner against a local model of the normal averaging.
// ---------------------------------------------------------------------------
module cube_vertex_normal_averager_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CUBE_SETS = 12;
   localparam int DIRECTED  = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cva_req_if req_bus ();
   cva_rsp_if rsp_bus ();

   cube_vertex_normal_averager_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // corner store and load count of the model
   logic signed [63:0]            corner_x [8];
   logic signed [63:0]            corner_y [8];
   logic signed [63:0]            corner_z [8];
   int unsigned                   corners_held = 0;
   cva_tb_pkg::corner_normal_type pending_normals [$];
   int                            mismatches = 0;
   bit                            long_hold = 1'b0;
   bit                            sending_done = 1'b0;

   // directed rows: a unit cube, then the largest cube the coordinates allow
   logic signed [31:0] row_x [DIRECTED];
   logic signed [31:0] row_y [DIRECTED];
   logic signed [31:0] row_z [DIRECTED];

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // (a*b)>>16 rounded toward minus infinity
   function automatic logic signed [63:0] q16_product(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >>> 16);
   endfunction

   function automatic logic signed [63:0] saturating_sum(input logic signed [63:0] a,
                                                          input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return 64'(s);
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] unit_component(input logic signed [63:0] s,
                                                          input logic [63:0] m,
                                                          input logic [63:0] len);
      logic [63:0] q;
      q = (m * 64'd32768 + len / 2) / len;
      if (q > 64'd32767) q = 64'd32767;
      return s < 0 ? -16'(q) : 16'(q);
   endfunction

   // sum the 12 triangle cross products into the corners and queue 8 normals
   task automatic predict_cube_normals();
      logic signed [63:0] sum_x [8];
      logic signed [63:0] sum_y [8];
      logic signed [63:0] sum_z [8];
      logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
      logic [63:0]        mx, my, mz, top, len;
      logic [2:0]         i0, i1, i2, ids [3];
      cva_tb_pkg::corner_normal_type r;
      for (int v = 0; v < 8; v++) begin
         sum_x[v] = 0; sum_y[v] = 0; sum_z[v] = 0;
      end
      for (int t = 0; t < 12; t++) begin
         i0 = cva_pkg::TRI_TABLE[t*3];
         i1 = cva_pkg::TRI_TABLE[t*3+1];
         i2 = cva_pkg::TRI_TABLE[t*3+2];
         ax = corner_x[i1] - corner_x[i0];
         ay = corner_y[i1] - corner_y[i0];
         az = corner_z[i1] - corner_z[i0];
         bx = corner_x[i2] - corner_x[i0];
         by = corner_y[i2] - corner_y[i0];
         bz = corner_z[i2] - corner_z[i0];
         cx = q16_product(ay, bz) - q16_product(az, by);
         cy = q16_product(az, bx) - q16_product(ax, bz);
         cz = q16_product(ax, by) - q16_product(ay, bx);
         ids[0] = i0; ids[1] = i1; ids[2] = i2;
         for (int j = 0; j < 3; j++) begin
            sum_x[ids[j]] = saturating_sum(sum_x[ids[j]], cx);
            sum_y[ids[j]] = saturating_sum(sum_y[ids[j]], cy);
            sum_z[ids[j]] = saturating_sum(sum_z[ids[j]], cz);
         end
      end
      for (int v = 0; v < 8; v++) begin
         r.vertex_index = 3'(v);
         r.px = 32'(corner_x[v]);
         r.py = 32'(corner_y[v]);
         r.pz = 32'(corner_z[v]);
         r.last = (v == 7);
         mx = magnitude(sum_x[v]); my = magnitude(sum_y[v]); mz = magnitude(sum_z[v]);
         if (mx == 0 && my == 0 && mz == 0) begin
            r.nx = 0; r.ny = cva_pkg::ONE_Q15; r.nz = 0;
         end else begin
            top = mx > my ? mx : my;
            if (mz > top) top = mz;
            while (top >= (64'd1 << 30)) begin
               top >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
            end
            while (top < (64'd1 << 29)) begin
               top <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
            end
            len = root_floor(mx * mx + my * my + mz * mz);
            r.nx = unit_component(sum_x[v], mx, len);
            r.ny = unit_component(sum_y[v], my, len);
            r.nz = unit_component(sum_z[v], mz, len);
         end
         pending_normals.insert(pending_normals.size(), r);
      end
   endtask

   task automatic take_corner(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z);
      corner_x[corners_held] = x;
      corner_y[corners_held] = y;
      corner_z[corners_held] = z;
      corners_held++;
      if (corners_held == 8) begin
         corners_held = 0;
         predict_cube_normals();
      end
   endtask

   // valid stays high after a request unless a gap follows
   task automatic send_corner(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pos_x <= x;
      req_bus.pos_y <= y;
      req_bus.pos_z <= z;
      do @(posedge clock); while (!req_bus.ready);
      take_corner(x, y, z);
   endtask

   function automatic logic signed [31:0] random_coord(input int shape);
      case (shape)
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 8)) * 32'sh0001_0000 - 32'sh0004_0000;
         default: return $signed(32'($urandom_range(0, 32'h000F_FFFF))) - 32'sh0008_0000;
      endcase
   endfunction

   initial begin
      req_bus.valid = 1'b0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      for (int i = 0; i < 8; i++) begin
         // corners of a unit cube
         row_x[i] = i[0] ? 32'sh0001_0000 : 32'sh0;
         row_y[i] = i[1] ? 32'sh0001_0000 : 32'sh0;
         row_z[i] = i[2] ? 32'sh0001_0000 : 32'sh0;
         // corners at the coordinate extremes
         row_x[8+i] = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         row_y[8+i] = i[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         row_z[8+i] = i[2] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // long receiver hold while the sender keeps offering
      long_hold = 1'b1;
      for (int i = 0; i < DIRECTED; i++) send_corner(row_x[i], row_y[i], row_z[i]);
      // degenerate set: every corner identical gives the default upward normal
      for (int i = 0; i < 8; i++) send_corner(32'sh1234_5678, -32'sh0000_0001, 32'sh0);
      for (int s = 0; s < CUBE_SETS; s++) begin
         int shape;
         shape = $urandom_range(0, 2);
         if (s == 3) begin
            // pause until the block has drained
            req_bus.valid <= 1'b0;
            while (pending_normals.size() != 0) @(posedge clock);
         end
         for (int i = 0; i < 8; i++) begin
            if (shape == 1 && $urandom_range(0, 1)) begin
               send_corner(i[0] ? 32'sh0002_0000 : -32'sh0002_0000,
                           i[1] ? 32'sh0002_0000 : -32'sh0002_0000,
                           i[2] ? 32'sh0002_0000 : -32'sh0002_0000);
            end else begin
               send_corner(random_coord(shape), random_coord(shape), random_coord(shape));
            end
         end
      end
      req_bus.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver with its own stall draw and one long hold
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (long_hold);
      @(posedge clock);
      repeat (3000) @(posedge clock);
      forever begin
         stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // compare each accepted corner with the oldest prediction
   always @(posedge clock) begin
      cva_tb_pkg::corner_normal_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected corner %0d", rsp_bus.vertex_index);
         end else begin
            want = pending_normals.pop_front();
            if (rsp_bus.vertex_index !== want.vertex_index || rsp_bus.out_pos_x !== want.px ||
                rsp_bus.out_pos_y !== want.py || rsp_bus.out_pos_z !== want.pz ||
                rsp_bus.normal_x !== want.nx || rsp_bus.normal_y !== want.ny ||
                rsp_bus.normal_z !== want.nz || rsp_bus.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"corner %0d: want pos %h %h %h n %0d %0d %0d l %b, ",
                            "got %0d %h %h %h n %0d %0d %0d l %b"},
                           want.vertex_index, want.px, want.py, want.pz, want.nx, want.ny,
                           want.nz, want.last, rsp_bus.vertex_index, rsp_bus.out_pos_x,
                           rsp_bus.out_pos_y, rsp_bus.out_pos_z, rsp_bus.normal_x,
                           rsp_bus.normal_y, rsp_bus.normal_z, rsp_bus.last);
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("cube_vertex_normal_averager_core_tb: PASS");
      end else begin
         $display("cube_vertex_normal_averager_core_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("cube_vertex_normal_averager_core_tb: FAIL");
      $finish;
   end

endmodule
